/* hdl/matre_pkg.sv */
// shared types and constants for the memory access trace record encoder
`default_nettype none

package matre_pkg;

  // address bits taken into the delta, 16 to 32
  localparam int ADDR_WIDTH = 32;

  // field widths of the event and beat words
  localparam int KIND_W   = 4;
  localparam int BANK_W   = 8;
  localparam int ADDR_W   = 32;
  localparam int CYCLE_W  = 64;
  localparam int DATA_W   = 64;
  localparam int BYTES_W  = 4;

  // kind codes
  localparam logic [KIND_W-1:0] KIND_LAST_PLAIN = 4'd8;
  localparam logic [7:0]        KIND_BASE       = 8'h01;
  localparam logic [7:0]        KIND_STOP       = 8'h10;

  // cycle byte escape value
  localparam logic [7:0] CYCLE_ESC = 8'hFF;

  // valid byte counts of the two beat kinds
  localparam logic [BYTES_W-1:0] BYTES_FIRST  = 4'd7;
  localparam logic [BYTES_W-1:0] BYTES_SECOND = 4'd8;

  // record queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one encoded record waiting for the back end
  typedef struct packed {
    logic [DATA_W-1:0]  first;
    logic               escaped;
    logic [CYCLE_W-1:0] cdelta;
  } rec_t;

endpackage

`default_nettype wire

/* hdl/matre_front.sv */
// front end: keeps previous address and cycle, builds the encoded record
`default_nettype none

module matre_front
  import matre_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic [KIND_W-1:0]  req_type,
  input  wire logic [BANK_W-1:0]  bank,
  input  wire logic [ADDR_W-1:0]  address,
  input  wire logic [CYCLE_W-1:0] cycle_number,
  output rec_t                    rec
);

  logic [ADDR_WIDTH-1:0] last_address;
  logic [CYCLE_W-1:0]    last_cycle;

  logic [ADDR_WIDTH-1:0] addr_w;
  logic [ADDR_WIDTH-1:0] d_fwd;
  logic [ADDR_WIDTH-1:0] d_back;
  logic [ADDR_WIDTH-1:0] enc_w;
  logic [7:0]            code;
  logic [CYCLE_W-1:0]    cdelta;
  logic                  escaped;
  logic [7:0]            cbyte;

  // kind code, undefined kinds fold into stop
  always_comb begin
    if (req_type <= KIND_LAST_PLAIN) begin
      code = KIND_BASE + 8'(req_type);
    end else begin
      code = KIND_STOP;
    end
  end

  // sign-magnitude address delta (magnitude shifted up, sign in bit 0), both directions computed side by side
  always_comb begin
    addr_w = address[ADDR_WIDTH-1:0];
    d_fwd  = addr_w - last_address;
    d_back = last_address - addr_w;
    if (d_fwd[ADDR_WIDTH-1]) begin
      enc_w = {d_back[ADDR_WIDTH-2:0], 1'b1};
    end else begin
      enc_w = {d_fwd[ADDR_WIDTH-2:0], 1'b0};
    end
  end

  // cycle delta and escape check
  always_comb begin
    cdelta  = cycle_number - last_cycle;
    escaped = (cdelta >= CYCLE_W'(CYCLE_ESC));
    cbyte   = escaped ? CYCLE_ESC : cdelta[7:0];
  end

  // record word for the queue
  always_comb begin
    rec.first   = {8'h00, cbyte, ADDR_W'(enc_w), bank, code};
    rec.escaped = escaped;
    rec.cdelta  = cdelta;
  end

  // previous event state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_address <= '0;
      last_cycle   <= '0;
    end else if (take) begin
      last_address <= addr_w;
      last_cycle   <= cycle_number;
    end
  end

endmodule

`default_nettype wire

/* hdl/matre_queue.sv */
// short record queue between front and back ends
`default_nettype none

module matre_queue
  import matre_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire rec_t wr_rec,
  output logic      full,
  input  wire logic rd,
  output rec_t      rd_rec,
  output logic      avail
);

  rec_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  // status and head word
  always_comb begin
    full   = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    avail  = (count != '0);
    rd_rec = slots[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/matre_back.sv */
// back end: splits records into beats and holds the output word
`default_nettype none

module matre_back
  import matre_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rec_t                rec,
  input  wire logic                avail,
  output logic                     rd,
  input  wire logic                pop,
  output logic                     empty,
  output logic [DATA_W-1:0]        beat_data,
  output logic [BYTES_W-1:0]       beat_bytes,
  output logic                     last_beat
);

  logic               out_valid;
  logic               second_pending;
  logic [CYCLE_W-1:0] held_cdelta;
  logic               can_load;

  // load the output word when it is free or being taken
  always_comb begin
    empty    = !out_valid;
    can_load = !out_valid || pop;
    rd       = can_load && !second_pending && avail;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (can_load) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else begin
        out_valid      <= avail;
        second_pending <= avail && rec.escaped;
      end
    end
  end

  // output word and held cycle delta
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (second_pending) begin
        beat_data  <= held_cdelta;
        beat_bytes <= BYTES_SECOND;
        last_beat  <= 1'b1;
      end else if (avail) begin
        beat_data   <= rec.first;
        beat_bytes  <= BYTES_FIRST;
        last_beat   <= !rec.escaped;
        held_cdelta <= rec.cdelta;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/memory_access_trace_record_encoder.sv */
// top level of the memory access trace record encoder
//
// Events enter through a queue-style port: an event is taken at a rising edge
// with push high and full low. Each event becomes one trace record: a 7-byte
// first word (kind code, bank, sign-magnitude address delta, cycle byte)
// and, when the cycle delta is 255 or more, an 8-byte second word with the
// full delta. Words leave through a queue-style port: while empty is low the
// oldest word is on beat_data, beat_bytes and last_beat, and pop takes it.
// A taken event is written into the record queue; the output register loads
// its first word from the queue head. One event is taken per cycle while full
// is low; the output register moves one word per cycle while pop is high.
// A four-entry record queue sits between the encoding front end and the word
// back end; when pop stays low the queue fills and full rises, and no word
// is dropped. Reset clears the previous address and cycle to zero and empties
// the queue and output register; no clearing pass is needed.
`default_nettype none

module memory_access_trace_record_encoder
  import matre_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [KIND_W-1:0]  req_type,
  input  wire logic [BANK_W-1:0]  bank,
  input  wire logic [ADDR_W-1:0]  address,
  input  wire logic [CYCLE_W-1:0] cycle_number,
  input  wire logic               pop,
  output logic                    empty,
  output logic [DATA_W-1:0]       beat_data,
  output logic [BYTES_W-1:0]      beat_bytes,
  output logic                    last_beat
);

  logic take;
  rec_t front_rec;
  rec_t head_rec;
  logic head_avail;
  logic head_rd;

  // event accept
  assign take = push && !full;

  // encoding front end
  matre_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .req_type     (req_type),
    .bank         (bank),
    .address      (address),
    .cycle_number (cycle_number),
    .rec          (front_rec)
  );

  // record queue
  matre_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (take),
    .wr_rec (front_rec),
    .full   (full),
    .rd     (head_rd),
    .rd_rec (head_rec),
    .avail  (head_avail)
  );

  // word back end
  matre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rec        (head_rec),
    .avail      (head_avail),
    .rd         (head_rd),
    .pop        (pop),
    .empty      (empty),
    .beat_data  (beat_data),
    .beat_bytes (beat_bytes),
    .last_beat  (last_beat)
  );

endmodule

`default_nettype wire
